[design/qsl_pkg.sv]
package qsl_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int VW    = 32;

    typedef logic [AW-1:0]        t_index;
    typedef logic [CW-1:0]        t_count;
    typedef logic signed [VW-1:0] t_value;

    typedef struct packed {
        t_index lo;
        t_index hi;
    } t_range;

endpackage

[design/qsl_if.sv]
interface qsl_in_if;
    logic                  valid;
    logic                  ready;
    qsl_pkg::t_value       value;
    logic                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface qsl_out_if;
    logic                  valid;
    logic                  ready;
    qsl_pkg::t_value       sorted_value;
    logic                  last_out;

    modport source (output valid, output sorted_value, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

[design/quicksort_lomuto_sorter.sv]
// Channel   Dir   Payload                    Handshake
// i_in      in    value[31:0], last          valid/ready
// o_out     out   sorted_value[31:0], last_out  valid/ready
//
// Loading accepts one word per cycle; ready is low from the word with last set
// until the final sorted word has been taken.
// Each partition step reads each element and compares it with the pivot, and
// each swap writes two elements, using the one read port and one write port of
// the element store; emitting reads each word and holds it until it is taken.
// Reset (synchronous, active low) empties the store and the range stack.
module quicksort_lomuto_sorter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qsl_in_if.sink       i_in,
    qsl_out_if.source    o_out
);
    import qsl_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_POP   = 4'd2;
    localparam logic [3:0] S_RANGE = 4'd3;
    localparam logic [3:0] S_PIV   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_SW1   = 4'd7;
    localparam logic [3:0] S_SW2   = 4'd8;
    localparam logic [3:0] S_FIN1  = 4'd9;
    localparam logic [3:0] S_FIN2  = 4'd10;
    localparam logic [3:0] S_PUSH2 = 4'd11;
    localparam logic [3:0] S_ORD   = 4'd12;
    localparam logic [3:0] S_OWAIT = 4'd13;
    localparam logic [3:0] S_OHOLD = 4'd14;

    logic [3:0] r_state, n_state;
    t_count     r_count, n_count;
    t_count     r_sp, n_sp;
    t_count     r_k, n_k;
    t_index     r_lo, n_lo;
    t_index     r_hi, n_hi;
    t_index     r_j, n_j;
    t_index     r_next, n_next;
    t_value     r_pivot, n_pivot;
    t_value     r_hold, n_hold;
    t_value     r_out_value, n_out_value;
    logic       r_out_last, n_out_last;
    logic       r_out_valid, n_out_valid;

    t_value     r_mem [DEPTH];
    t_value     r_mem_q;
    t_range     r_stk [DEPTH];
    t_range     r_stk_q;

    logic       mem_we;
    t_index     mem_wa, mem_ra;
    t_value     mem_wd;
    logic       stk_we;
    t_index     stk_wa, stk_ra;
    t_range     stk_wd;
    logic       in_acc;
    logic       push_lo, push_hi;

    assign in_acc  = i_in.valid && i_in.ready;
    assign push_lo = {1'b0, r_next} > ({1'b0, r_lo} + 1'b1);
    assign push_hi = ({1'b0, r_next} + 1'b1) < {1'b0, r_hi};

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.last_out     = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sp        = r_sp;
        n_k         = r_k;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_j         = r_j;
        n_next      = r_next;
        n_pivot     = r_pivot;
        n_hold      = r_hold;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_wa      = r_next;
        mem_wd      = r_hold;
        mem_ra      = r_j;
        stk_we      = 1'b0;
        stk_wa      = r_sp[AW-1:0];
        stk_wd      = '{lo: r_lo, hi: r_hi};
        stk_ra      = r_sp[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_count < t_count'(DEPTH)) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_count[AW-1:0];
                        mem_wd  = i_in.value;
                        n_count = r_count + 1'b1;
                    end
                    if (i_in.last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_k = '0;
                if (r_count < t_count'(2)) begin
                    n_state = S_ORD;
                end else begin
                    stk_we  = 1'b1;
                    stk_wa  = '0;
                    stk_wd  = '{lo: '0, hi: t_index'(r_count - 1'b1)};
                    n_sp    = t_count'(1);
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    stk_ra  = t_index'(r_sp - 1'b1);
                    n_sp    = r_sp - 1'b1;
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                n_lo    = r_stk_q.lo;
                n_hi    = r_stk_q.hi;
                mem_ra  = r_stk_q.hi;
                n_state = S_PIV;
            end
            S_PIV: begin
                n_pivot = r_mem_q;
                n_j     = r_lo;
                n_next  = r_lo;
                n_state = S_RD;
            end
            S_RD: begin
                if (r_j == r_hi) begin
                    mem_ra  = r_next;
                    n_state = S_FIN1;
                end else begin
                    mem_ra  = r_j;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_mem_q <= r_pivot) begin
                    if (r_next == r_j) begin
                        n_next  = r_next + 1'b1;
                        n_j     = r_j + 1'b1;
                        n_state = S_RD;
                    end else begin
                        n_hold  = r_mem_q;
                        mem_ra  = r_next;
                        n_state = S_SW1;
                    end
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_RD;
                end
            end
            S_SW1: begin
                mem_we  = 1'b1;
                mem_wa  = r_next;
                mem_wd  = r_hold;
                n_hold  = r_mem_q;
                n_state = S_SW2;
            end
            S_SW2: begin
                mem_we  = 1'b1;
                mem_wa  = r_j;
                mem_wd  = r_hold;
                n_next  = r_next + 1'b1;
                n_j     = r_j + 1'b1;
                n_state = S_RD;
            end
            S_FIN1: begin
                mem_we  = 1'b1;
                mem_wa  = r_next;
                mem_wd  = r_pivot;
                n_hold  = r_mem_q;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                mem_we = 1'b1;
                mem_wa = r_hi;
                mem_wd = r_hold;
                if (push_lo) begin
                    stk_we = 1'b1;
                    stk_wd = '{lo: r_lo, hi: r_next - 1'b1};
                    n_sp   = r_sp + 1'b1;
                end
                n_state = S_PUSH2;
            end
            S_PUSH2: begin
                if (push_hi) begin
                    stk_we = 1'b1;
                    stk_wd = '{lo: r_next + 1'b1, hi: r_hi};
                    n_sp   = r_sp + 1'b1;
                end
                n_state = S_POP;
            end
            S_ORD: begin
                mem_ra  = r_k[AW-1:0];
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                n_out_value = r_mem_q;
                n_out_last  = (r_k == r_count - 1'b1);
                n_out_valid = 1'b1;
                n_state     = S_OHOLD;
            end
            S_OHOLD: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count = '0;
                        n_sp    = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sp        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sp        <= n_sp;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_j         <= n_j;
        r_next      <= n_next;
        r_pivot     <= n_pivot;
        r_hold      <= n_hold;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_wa] <= stk_wd;
        end
        r_stk_q <= r_stk[stk_ra];
    end

    a_out_only_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_state == S_OHOLD))
        else $error("output word valid outside hold state");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while output word pending");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= t_count'(DEPTH))
        else $error("range stack overflow");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last) |=> (r_state == S_START))
        else $error("last word did not start sort");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OWAIT) |-> (r_k < r_count))
        else $error("emit index beyond stored count");

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qsl_pkg::*;

    localparam int IDLE_LIMIT   = 100000;
    localparam int TARGET_WORDS = 350;
    localparam int SETTLE       = 50;

    typedef enum int {
        PAT_RANDOM,
        PAT_CLUSTER,
        PAT_RISING,
        PAT_FALLING,
        PAT_EXTREME
    } t_pattern;

    class sort_scoreboard;
        t_value open_set[$];
        t_value sorted_q[$];
        logic   last_q[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction

        // Hold at most DEPTH values; a closing word releases the whole set in order.
        function void note_word(t_value v, logic lst);
            t_value ordered[$];
            int     pos;
            if (open_set.size() < DEPTH) open_set.push_back(v);
            if (!lst) return;
            foreach (open_set[i]) begin
                pos = 0;
                while (pos < ordered.size() && ordered[pos] <= open_set[i]) pos++;
                ordered.insert(pos, open_set[i]);
            end
            foreach (ordered[k]) begin
                sorted_q.push_back(ordered[k]);
                last_q.push_back(k == ordered.size() - 1);
            end
            open_set.delete();
        endfunction

        function void check_word(t_value v, logic lst);
            t_value exp_v;
            logic   exp_l;
            if (sorted_q.size() == 0) begin
                $display("%0t: unexpected word sorted_value=%0d last_out=%0b", $time, v, lst);
                errors++;
                return;
            end
            exp_v = sorted_q.pop_front();
            exp_l = last_q.pop_front();
            if (v !== exp_v) begin
                $display("%0t: sorted_value expected %0d got %0d", $time, exp_v, v);
                errors++;
            end
            if (lst !== exp_l) begin
                $display("%0t: last_out expected %0b got %0b", $time, exp_l, lst);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    qsl_in_if  in_if();
    qsl_out_if out_if();

    quicksort_lomuto_sorter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sort_scoreboard sb;
    bit             send_calm;
    int             loaded_words;
    int             idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_value make_value(t_pattern pat, int idx, int n);
        case (pat)
            PAT_CLUSTER: return t_value'(int'($urandom_range(0, 8)) - 4);
            PAT_RISING:  return t_value'(idx - n / 2);
            PAT_FALLING: return t_value'(n - idx);
            PAT_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default:     return t_value'($urandom);
        endcase
    endfunction

    // Called right after a falling edge; returns right after a falling edge.
    task automatic send_word(input t_value v, input logic lst);
        int gap;
        in_if.valid <= 1'b1;
        in_if.value <= v;
        in_if.last  <= lst;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
        gap = send_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_values(input t_value vals[$]);
        foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
        loaded_words += (vals.size() > DEPTH) ? DEPTH : vals.size();
    endtask

    task automatic send_set(input int n, input t_pattern pat);
        for (int i = 0; i < n; i++) send_word(make_value(pat, i, n), i == n - 1);
        loaded_words += (n > DEPTH) ? DEPTH : n;
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            sb.note_word(in_if.value, in_if.last);
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_word(out_if.sorted_value, out_if.last_out);
    end

    initial begin
        int stall_left;
        int calm_left;
        out_if.ready = 1'b0;
        stall_left   = 0;
        calm_left    = 0;
        forever begin
            @(negedge i_clk);
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (calm_left == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        idle_cycles = 0;
        do begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end while (idle_cycles < IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int       sets;
        int       n;
        int       r;
        t_pattern pat;

        sb           = new();
        in_if.valid  = 1'b0;
        in_if.value  = '0;
        in_if.last   = 1'b0;
        i_rst_n      = 1'b0;
        send_calm    = 1'b0;
        loaded_words = 0;
        sets         = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_values('{32'h7fff_ffff});
        send_values('{32'h8000_0000});
        send_values('{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1,
                      32'h5, 32'h5, 32'hffff_fffb});
        send_values('{32'h4, 32'h3, 32'h2, 32'h1, 32'h0});
        send_values('{32'h7, 32'h7, 32'h7});
        send_values('{32'hffff_fffd, 32'hffff_fffe, 32'hffff_ffff, 32'h0, 32'h1, 32'h2});
        wait_drained();

        // Fill the store exactly, then overrun it with the closing word dropped.
        send_set(DEPTH, PAT_RANDOM);
        send_set(DEPTH + 6, PAT_CLUSTER);
        wait_drained();

        while (loaded_words < TARGET_WORDS) begin
            send_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)      n = $urandom_range(1, 8);
            else if (r < 90) n = $urandom_range(9, 30);
            else if (r < 97) n = $urandom_range(31, DEPTH);
            else             n = $urandom_range(DEPTH + 1, DEPTH + 8);
            r = $urandom_range(0, 99);
            if (r < 55)      pat = PAT_RANDOM;
            else if (r < 75) pat = PAT_CLUSTER;
            else if (r < 84) pat = PAT_RISING;
            else if (r < 92) pat = PAT_FALLING;
            else             pat = PAT_EXTREME;
            send_set(n, pat);
            sets++;
            if (sets % 8 == 0) wait_drained();
        end

        in_if.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[quicksort_lomuto_sorter.f]
design/qsl_pkg.sv
design/qsl_if.sv
design/quicksort_lomuto_sorter.sv
tb/testbench.sv
